// File: hw/rtl/dqd_pkg.sv
// package for the deque with delete by value
// widths, mode and status codes, beat structs and the cell link types
// no dependencies
package dqd_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int COUNT_W    = $clog2(DEPTH + 1);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [COUNT_W-1:0]    count_t;

	localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
	localparam logic [2:0] MODE_POP_BACK   = 3'd1;
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd2;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [2:0] MODE_DELETE     = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [1:0]         status;
		logic [6:0]         entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_POP_FRONT,
		OP_PUSH_BACK,
		OP_POP_BACK,
		OP_COMPARE,
		OP_WALK,
		OP_COMPACT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		word_t    value;
	} cell_cmd_t;

	typedef struct packed {
		logic  valid;
		word_t data;
		logic  seen;
	} link_t;

endpackage

// File: hw/rtl/dqd_cell.sv
// one storage cell of the deque chain
// holds one entry, a match flag and the delete prefix flag; depends on dqd_pkg
module dqd_cell import dqd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  link_t     prev,
	input  link_t     next,
	output link_t     own,
	output logic      match,
	output word_t     tail_word
);

	logic  valid_q;
	logic  seen_q;
	logic  match_q;
	word_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seen_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_PUSH_FRONT: valid_q <= prev.valid;
				OP_POP_FRONT:  valid_q <= next.valid;
				OP_PUSH_BACK:  valid_q <= valid_q | prev.valid;
				OP_POP_BACK:   valid_q <= valid_q & next.valid;
				OP_COMPARE: begin
					match_q <= valid_q && (data_q == cmd.value);
					seen_q  <= 1'b0;
				end
				OP_WALK:       seen_q <= prev.seen | match_q;
				OP_COMPACT: begin
					if (seen_q) begin
						valid_q <= next.valid;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PUSH_FRONT: data_q <= prev.data;
			OP_POP_FRONT:  data_q <= next.data;
			OP_PUSH_BACK: begin
				if (!valid_q && prev.valid) begin
					data_q <= cmd.value;
				end
			end
			OP_COMPACT: begin
				if (seen_q) begin
					data_q <= next.data;
				end
			end
			default: ;
		endcase
	end

	assign own.valid = valid_q;
	assign own.data  = data_q;
	assign own.seen  = seen_q;
	assign match     = match_q;
	assign tail_word = (valid_q && !next.valid) ? data_q : '0;

endmodule

// File: hw/rtl/deque_with_delete_by_value.sv
// top level of the deque with delete by value: request sequencer and cell chain
// depends on dqd_pkg and dqd_cell
//
// A request is taken when start is high and busy is low; its result appears on
// rsp as done goes high for exactly one cycle, and it cannot be held off. Pushes,
// pops and unused modes pass through one execute state and return to idle. A
// delete compares in every cell at once, then walks the first-match flag one
// cell per cycle along the occupied entries and closes the gap in one shift;
// it passes through the execute, walk and shift states in that order.
module deque_with_delete_by_value import dqd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_SHIFT} state_t;

	state_t    state_q, state_d;
	req_t      req_q;
	count_t    count_q, count_d;
	count_t    walk_q, walk_d;
	logic      done_q, done_d;
	rsp_t      rsp_q, rsp_d;
	cell_cmd_t cmd;

	link_t cell_link [DEPTH];
	link_t prev_link [DEPTH];
	link_t next_link [DEPTH];
	logic  cell_match [DEPTH];
	word_t cell_tail [DEPTH];
	word_t tail_or;
	logic  found;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_link[i] = '{valid: 1'b1, data: cmd.value, seen: 1'b0};
		end else begin : g_body
			assign prev_link[i] = cell_link[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_link[i] = '0;
		end else begin : g_inner
			assign next_link[i] = cell_link[i+1];
		end
		dqd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.prev      (prev_link[i]),
			.next      (next_link[i]),
			.own       (cell_link[i]),
			.match     (cell_match[i]),
			.tail_word (cell_tail[i])
		);
	end

	always_comb begin
		tail_or = '0;
		found   = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_or = tail_or | cell_tail[i];
			found   = found | cell_match[i];
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		walk_d    = walk_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		cmd.op    = OP_HOLD;
		cmd.value = word_t'(req_q.value);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d           = S_IDLE;
				done_d            = 1'b1;
				rsp_d.value_out   = '0;
				rsp_d.status      = ST_OK;
				unique case (req_q.mode) inside
					MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
						if (count_q == count_t'(DEPTH)) begin
							rsp_d.status = ST_FULL;
						end else begin
							cmd.op  = (req_q.mode == MODE_PUSH_BACK) ? OP_PUSH_BACK
								: OP_PUSH_FRONT;
							count_d = count_q + count_t'(1);
						end
					end
					MODE_POP_BACK: begin
						if (count_q == '0) begin
							rsp_d.status = ST_EMPTY;
						end else begin
							cmd.op          = OP_POP_BACK;
							rsp_d.value_out = 32'(signed'(tail_or));
							count_d         = count_q - count_t'(1);
						end
					end
					MODE_POP_FRONT: begin
						if (count_q == '0) begin
							rsp_d.status = ST_EMPTY;
						end else begin
							cmd.op          = OP_POP_FRONT;
							rsp_d.value_out = 32'(signed'(cell_link[0].data));
							count_d         = count_q - count_t'(1);
						end
					end
					MODE_DELETE: begin
						cmd.op  = OP_COMPARE;
						walk_d  = '0;
						done_d  = 1'b0;
						state_d = S_WALK;
					end
					default: ;
				endcase
				rsp_d.entry_count = 7'(count_d);
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				walk_d = walk_q + count_t'(1);
				if (walk_q == count_q) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				state_d         = S_IDLE;
				done_d          = 1'b1;
				rsp_d.value_out = '0;
				if (found) begin
					cmd.op       = OP_COMPACT;
					count_d      = count_q - count_t'(1);
					rsp_d.status = ST_OK;
				end else begin
					rsp_d.status = ST_NOTFOUND;
				end
				rsp_d.entry_count = 7'(count_d);
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			walk_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			walk_q  <= walk_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
